### rtl/dftl_pkg.sv
// Shared types, scanner mode codes and character helpers for the token lexer.
`default_nettype none
package dftl_pkg;

    localparam int LINE_BITS = 20;
    localparam logic [LINE_BITS-1:0] LINE_TOP = {LINE_BITS{1'b1}};

    // Scanner modes.
    localparam logic [4:0] M_IDLE      = 5'd0;
    localparam logic [4:0] M_IDENT     = 5'd1;
    localparam logic [4:0] M_SIGN      = 5'd2;
    localparam logic [4:0] M_ZERO      = 5'd3;
    localparam logic [4:0] M_DEC       = 5'd4;
    localparam logic [4:0] M_OCT       = 5'd5;
    localparam logic [4:0] M_BIN       = 5'd6;
    localparam logic [4:0] M_HEX       = 5'd7;
    localparam logic [4:0] M_FDOT      = 5'd8;
    localparam logic [4:0] M_FFRAC     = 5'd9;
    localparam logic [4:0] M_FEXP      = 5'd10;
    localparam logic [4:0] M_FESIGN    = 5'd11;
    localparam logic [4:0] M_FEDIG     = 5'd12;
    localparam logic [4:0] M_CH_OPEN   = 5'd13;
    localparam logic [4:0] M_CH_ESC    = 5'd14;
    localparam logic [4:0] M_CH_EMPTY  = 5'd15;
    localparam logic [4:0] M_CH_HELD   = 5'd16;
    localparam logic [4:0] M_CH_CLOSE  = 5'd17;
    localparam logic [4:0] M_STR       = 5'd18;
    localparam logic [4:0] M_STR_ESC   = 5'd19;
    localparam logic [4:0] M_STR_CLOSE = 5'd20;
    localparam logic [4:0] M_C_SLASH   = 5'd21;
    localparam logic [4:0] M_C_BLOCK   = 5'd22;
    localparam logic [4:0] M_C_STAR    = 5'd23;
    localparam logic [4:0] M_C_LINE    = 5'd24;

    // Token kinds.
    localparam logic [3:0] K_END   = 4'd0;
    localparam logic [3:0] K_BAD   = 4'd1;
    localparam logic [3:0] K_IDENT = 4'd2;
    localparam logic [3:0] K_BOOL  = 4'd3;
    localparam logic [3:0] K_UNS   = 4'd4;
    localparam logic [3:0] K_SGN   = 4'd5;
    localparam logic [3:0] K_FLOAT = 4'd6;
    localparam logic [3:0] K_CHAR  = 4'd7;
    localparam logic [3:0] K_STR   = 4'd8;
    localparam logic [3:0] K_OP    = 4'd9;

    // Diagnostics.
    localparam logic [2:0] D_NONE    = 3'd0;
    localparam logic [2:0] D_NUMBER  = 3'd1;
    localparam logic [2:0] D_CHAR    = 3'd2;
    localparam logic [2:0] D_STRING  = 3'd3;
    localparam logic [2:0] D_EOF     = 3'd4;
    localparam logic [2:0] D_COMMENT = 3'd5;

    // Keyword tracking codes.
    localparam logic [2:0] KW_NONE   = 3'd0;
    localparam logic [2:0] KW_TRUE   = 3'd1;
    localparam logic [2:0] KW_FALSE  = 3'd2;
    localparam logic [2:0] KW_EITHER = 3'd7;

    localparam logic [31:0] DEC_LIMIT = 32'd429496729;

    typedef struct packed {
        logic [4:0]           mode;
        logic [31:0]          acc;
        logic [1:0]           sgn;   // bit 0 signed, bit 1 negative
        logic                 ovf;
        logic                 digs;
        logic [LINE_BITS-1:0] line;
        logic [LINE_BITS-1:0] sline;
        logic [2:0]           kw;
        logic [7:0]           held;
        logic                 esc;
    } lex_state_t;

    typedef struct packed {
        logic                 txt;
        logic [7:0]           tb;
        logic [3:0]           kind;
        logic [31:0]          val;
        logic                 ovf;
        logic [2:0]           diag;
        logic [LINE_BITS-1:0] line;
    } lex_result_t;

    typedef struct packed {
        lex_result_t [1:0] slot;
        logic [1:0]        count;
    } lex_batch_t;

    function automatic logic is_ws(input logic [7:0] c);
        return c == " " || c == 8'h09;
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return c == "{" || c == "}" || c == "[" || c == "]" || c == ";" || c == ",";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        if (is_dig(c)) t = c - "0";
        else if (c >= "a" && c <= "f") t = c - "a" + 8'd10;
        else t = c - "A" + 8'd10;
        return t[3:0];
    endfunction

    function automatic logic [7:0] esc_map(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            "a": r = 8'd7;
            "b": r = 8'd8;
            "t": r = 8'd9;
            "n": r = 8'd10;
            "v": r = 8'd11;
            "f": r = 8'd12;
            "r": r = 8'd13;
            "0": r = 8'd0;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic logic follow_ok(input logic [7:0] c, input logic eof);
        return eof || is_op(c) || is_ws(c) || c == 8'h0A || c == "/";
    endfunction

    function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] l);
        return (l != LINE_TOP) ? l + 1'b1 : l;
    endfunction

    // Next keyword match given the position so far and the new byte.
    function automatic logic [2:0] kw_next(input logic [2:0] kw, input logic [31:0] pos,
                                           input logic [7:0] c);
        logic [7:0] lc;
        logic [7:0] want;
        logic [2:0] r;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        r  = KW_NONE;
        if (kw == KW_EITHER) begin
            if (pos == 32'd0 && lc == "t") r = KW_TRUE;
            else if (pos == 32'd0 && lc == "f") r = KW_FALSE;
        end else if (kw == KW_TRUE) begin
            unique case (pos[1:0])
                2'd0: want = "t";
                2'd1: want = "r";
                2'd2: want = "u";
                default: want = "e";
            endcase
            if (pos < 32'd4 && lc == want) r = KW_TRUE;
        end else if (kw == KW_FALSE) begin
            unique case (pos[2:0])
                3'd0: want = "f";
                3'd1: want = "a";
                3'd2: want = "l";
                3'd3: want = "s";
                default: want = "e";
            endcase
            if (pos < 32'd5 && lc == want) r = KW_FALSE;
        end
        return r;
    endfunction

    function automatic lex_result_t mk_tok(input logic [3:0] kind, input logic [31:0] val,
                                           input logic ovf, input logic [2:0] diag,
                                           input logic [LINE_BITS-1:0] line);
        lex_result_t r;
        r.txt  = 1'b0;
        r.tb   = 8'd0;
        r.kind = kind;
        r.val  = val;
        r.ovf  = ovf;
        r.diag = diag;
        r.line = line;
        return r;
    endfunction

    function automatic lex_result_t mk_text(input logic [7:0] tb, input logic [3:0] kind,
                                            input logic [LINE_BITS-1:0] line);
        lex_result_t r;
        r      = mk_tok(kind, 32'd0, 1'b0, D_NONE, line);
        r.txt  = 1'b1;
        r.tb   = tb;
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/dftl_step.sv
// Next-state and result logic for one source byte of the token lexer.
`default_nettype none
module dftl_step (
    input  dftl_pkg::lex_state_t st,
    input  logic [7:0]           c,
    input  logic                 eof,
    output dftl_pkg::lex_state_t ns,
    output dftl_pkg::lex_batch_t batch
);
    import dftl_pkg::*;

    lex_result_t ra;
    lex_result_t rb;
    logic        va;
    logic        vb;
    logic        rescan;
    logic        take;
    logic        ov;
    logic        sgn;
    logic        neg;

    assign sgn = st.sgn[0];
    assign neg = st.sgn[1];

    // Overflow of a finished integer, signed range included.
    assign ov = st.ovf | (sgn & ((!neg & (st.acc > 32'h7FFFFFFF)) |
                                 (neg & (st.acc > 32'h80000000))));

    always_comb begin
        ns     = st;
        ra     = '0;
        rb     = '0;
        va     = 1'b0;
        vb     = 1'b0;
        rescan = 1'b0;
        take   = 1'b0;

        // Continue or close the token in progress.
        unique case (st.mode)
            M_IDENT: begin
                va = 1'b1;
                if (!eof && (is_alpha(c) || is_dig(c) || c == "_")) begin
                    ns.kw  = kw_next(st.kw, st.acc, c);
                    ns.acc = (st.acc < 32'd255) ? st.acc + 32'd1 : st.acc;
                    ra     = mk_text(c, K_IDENT, st.line);
                end else begin
                    rescan = 1'b1;
                    if (st.kw == KW_TRUE && st.acc == 32'd4)
                        ra = mk_tok(K_BOOL, 32'd1, 1'b0, D_NONE, st.line);
                    else if (st.kw == KW_FALSE && st.acc == 32'd5)
                        ra = mk_tok(K_BOOL, 32'd0, 1'b0, D_NONE, st.line);
                    else
                        ra = mk_tok(K_IDENT, 32'd0, 1'b0, D_NONE, st.line);
                end
            end
            M_SIGN: begin
                if (!eof && is_dig(c)) begin
                    ns.ovf  = 1'b0;
                    ns.digs = 1'b0;
                    ns.mode = (c == "0") ? M_ZERO : M_DEC;
                    ns.acc  = {24'd0, c - "0"};
                end else begin
                    va     = 1'b1;
                    rescan = 1'b1;
                    ra = neg ? mk_tok(K_BAD, 32'd0, 1'b0, D_NUMBER, st.line)
                             : mk_tok(K_OP, {24'd0, 8'h2B}, 1'b0, D_NONE, st.line);
                end
            end
            M_ZERO: begin
                if (eof || (c != "b" && !is_dig(c) && c != "x" && c != "." &&
                            c != "e" && c != "E")) begin
                    va = 1'b1;
                    rescan = 1'b1;
                    ra = mk_tok(sgn ? K_SGN : K_UNS, 32'd0, 1'b0, D_NONE, st.line);
                end else begin
                    ns.acc  = 32'd0;
                    ns.digs = 1'b0;
                    if (c == "b") ns.mode = M_BIN;
                    else if (c <= "7" && is_dig(c)) begin
                        ns.mode = M_OCT;
                        ns.acc  = {24'd0, c - "0"};
                    end else if (c == "x") ns.mode = M_HEX;
                    else if (c == ".") ns.mode = M_FDOT;
                    else if (c == "e" || c == "E") ns.mode = M_FEXP;
                    else begin
                        // Zero followed by 8 or 9: the digit is consumed.
                        va      = 1'b1;
                        ra      = mk_tok(K_BAD, 32'd0, 1'b0, D_NONE, st.line);
                        ns.mode = M_IDLE;
                    end
                end
            end
            M_DEC: begin
                if (!eof && is_dig(c)) begin
                    if (st.acc > DEC_LIMIT || (st.acc == DEC_LIMIT && c > "5"))
                        ns.ovf = 1'b1;
                    ns.acc = (st.acc << 3) + (st.acc << 1) + {24'd0, c - "0"};
                end else if (!eof && (c == "." || c == "e" || c == "E")) begin
                    ns.mode = (c == ".") ? M_FDOT : M_FEXP;
                end else begin
                    va = 1'b1;
                    rescan = 1'b1;
                end
            end
            M_OCT: begin
                if (!eof && c >= "0" && c <= "7") begin
                    if ((st.acc & 32'hE0000000) != 32'd0) ns.ovf = 1'b1;
                    ns.acc = (st.acc << 3) + {24'd0, c - "0"};
                end else begin
                    va = 1'b1;
                    rescan = 1'b1;
                end
            end
            M_BIN: begin
                if (!eof && (c == "0" || c == "1")) begin
                    if (st.acc[31]) ns.ovf = 1'b1;
                    ns.acc  = {st.acc[30:0], c[0]};
                    ns.digs = 1'b1;
                end else begin
                    va = 1'b1;
                    rescan = 1'b1;
                end
            end
            M_HEX: begin
                if (!eof && is_hex(c)) begin
                    if ((st.acc & 32'hF0000000) != 32'd0) ns.ovf = 1'b1;
                    ns.acc  = {st.acc[27:0], hex_val(c)};
                    ns.digs = 1'b1;
                end else begin
                    va = 1'b1;
                    rescan = 1'b1;
                end
            end
            M_FDOT, M_FESIGN: begin
                if (!eof && is_dig(c)) begin
                    ns.mode = (st.mode == M_FDOT) ? M_FFRAC : M_FEDIG;
                end else begin
                    va = 1'b1;
                    rescan = 1'b1;
                    ra = mk_tok(K_BAD, 32'd0, 1'b0, D_NONE, st.line);
                end
            end
            M_FFRAC, M_FEDIG: begin
                if (!eof && is_dig(c)) begin
                    ns.mode = st.mode;
                end else if (st.mode == M_FFRAC && !eof && (c == "e" || c == "E")) begin
                    ns.mode = M_FEXP;
                end else begin
                    va = 1'b1;
                    rescan = 1'b1;
                    ra = mk_tok(follow_ok(c, eof) ? K_FLOAT : K_BAD, 32'd0, 1'b0,
                                D_NONE, st.line);
                end
            end
            M_FEXP: begin
                if (!eof && (c == "+" || c == "-")) ns.mode = M_FESIGN;
                else if (!eof && is_dig(c)) ns.mode = M_FEDIG;
                else begin
                    va = 1'b1;
                    rescan = 1'b1;
                    ra = mk_tok(K_BAD, 32'd0, 1'b0, D_NONE, st.line);
                end
            end
            M_CH_OPEN, M_CH_ESC: begin
                if (eof) begin
                    va = 1'b1;
                    rescan = 1'b1;
                    ra = mk_tok(K_BAD, 32'd0, 1'b0, D_EOF, st.line);
                end else if (st.mode == M_CH_OPEN && c == 8'h5C) begin
                    ns.esc  = 1'b1;
                    ns.mode = M_CH_ESC;
                end else begin
                    take = 1'b1;
                end
            end
            M_CH_EMPTY: begin
                va = 1'b1;
                ra = mk_tok(K_BAD, 32'd0, 1'b0, D_CHAR, st.line);
                // A third quote right after an empty literal is swallowed.
                if (!eof && c == 8'h27) ns.mode = M_IDLE;
                else rescan = 1'b1;
            end
            M_CH_HELD: begin
                if (!eof && c == 8'h27) begin
                    ns.mode = M_CH_CLOSE;
                end else begin
                    va = 1'b1;
                    rescan = 1'b1;
                    ra = mk_tok(K_BAD, 32'd0, 1'b0, eof ? D_EOF : D_CHAR, st.line);
                end
            end
            M_CH_CLOSE: begin
                va = 1'b1;
                rescan = 1'b1;
                if (follow_ok(c, eof))
                    ra = mk_tok(K_CHAR, {24'd0, st.esc ? esc_map(st.held) : st.held},
                                1'b0, D_NONE, st.line);
                else
                    ra = mk_tok(K_BAD, 32'd0, 1'b0, D_NONE, st.line);
            end
            M_STR, M_STR_ESC: begin
                if (eof) begin
                    va = 1'b1;
                    rescan = 1'b1;
                    ra = mk_tok(K_BAD, 32'd0, 1'b0, D_STRING, st.sline);
                end else if (st.mode == M_STR && c == 8'h22) begin
                    ns.mode = M_STR_CLOSE;
                end else if (st.mode == M_STR && c == 8'h5C) begin
                    ns.mode = M_STR_ESC;
                end else begin
                    ns.mode = M_STR;
                    if (c == 8'h0A) ns.line = line_inc(st.line);
                    // An escaped newline is a line continuation and emits nothing.
                    if (st.mode == M_STR) begin
                        va = 1'b1;
                        ra = mk_text(c, K_STR, ns.line);
                    end else if (c != 8'h0A) begin
                        va = 1'b1;
                        ra = mk_text(esc_map(c), K_STR, ns.line);
                    end
                end
            end
            M_STR_CLOSE: begin
                va = 1'b1;
                rescan = 1'b1;
                ra = mk_tok(follow_ok(c, eof) ? K_STR : K_BAD, 32'd0, 1'b0, D_NONE, st.line);
            end
            M_C_SLASH: begin
                if (!eof && c == "*") ns.mode = M_C_BLOCK;
                else if (!eof && c == "/") ns.mode = M_C_LINE;
                else begin
                    va = 1'b1;
                    rescan = 1'b1;
                    ra = mk_tok(K_BAD, 32'd0, 1'b0, D_NONE, st.line);
                end
            end
            M_C_BLOCK, M_C_STAR: begin
                if (eof) begin
                    va = 1'b1;
                    ra = mk_tok(K_END, 32'd0, 1'b0, D_COMMENT, st.line);
                    ns.mode = M_IDLE;
                end else if (st.mode == M_C_STAR && c == "/") begin
                    ns.mode = M_IDLE;
                end else if (c == "*") begin
                    ns.mode = M_C_STAR;
                end else begin
                    if (c == 8'h0A) ns.line = line_inc(st.line);
                    ns.mode = M_C_BLOCK;
                end
            end
            M_C_LINE: begin
                if (eof) begin
                    va = 1'b1;
                    ra = mk_tok(K_END, 32'd0, 1'b0, D_COMMENT, st.line);
                    ns.mode = M_IDLE;
                end else if (c == 8'h0A) begin
                    ns.line = line_inc(st.line);
                    ns.mode = M_IDLE;
                end
            end
            default: rescan = 1'b1;
        endcase

        // Integer close for decimal, octal, binary and hex.
        if (va && (st.mode == M_DEC || st.mode == M_OCT || st.mode == M_BIN ||
                   st.mode == M_HEX)) begin
            if ((st.mode == M_BIN || st.mode == M_HEX) && !st.digs)
                ra = mk_tok(K_BAD, 32'd0, 1'b0, D_NUMBER, st.line);
            else if (!follow_ok(c, eof))
                ra = mk_tok(K_BAD, 32'd0, 1'b0, D_NONE, st.line);
            else if (sgn)
                ra = mk_tok(K_SGN, neg ? 32'd0 - st.acc : st.acc, ov, D_NONE, st.line);
            else
                ra = mk_tok(K_UNS, st.acc, ov, D_NONE, st.line);
        end

        // Character body byte, plain or after a backslash.
        if (take) begin
            if (!ns.esc && c == 8'h27) begin
                ns.mode = M_CH_EMPTY;
            end else if (c == 8'h0A) begin
                ns.line = line_inc(st.line);
                va      = 1'b1;
                ra      = mk_tok(K_BAD, 32'd0, 1'b0, D_CHAR, ns.line);
                ns.mode = M_IDLE;
            end else begin
                ns.held = c;
                ns.mode = M_CH_HELD;
            end
        end

        // Scan the byte as the start of a new token.
        if (rescan) begin
            ns.mode = M_IDLE;
            if (eof) begin
                vb = 1'b1;
                rb = mk_tok(K_END, 32'd0, 1'b0, D_NONE, ns.line);
            end else if (is_ws(c)) begin
                vb = 1'b0;
            end else if (is_alpha(c) || c == "_") begin
                ns.mode = M_IDENT;
                ns.kw   = kw_next(KW_EITHER, 32'd0, c);
                ns.acc  = 32'd1;
                vb      = 1'b1;
                rb      = mk_text(c, K_IDENT, ns.line);
            end else if (is_op(c)) begin
                vb = 1'b1;
                rb = mk_tok(K_OP, {24'd0, c}, 1'b0, D_NONE, ns.line);
            end else if (is_dig(c)) begin
                ns.sgn  = 2'b00;
                ns.ovf  = 1'b0;
                ns.digs = 1'b0;
                ns.mode = (c == "0") ? M_ZERO : M_DEC;
                ns.acc  = {24'd0, c - "0"};
            end else if (c == "+" || c == "-") begin
                ns.sgn  = {c == "-", 1'b1};
                ns.mode = M_SIGN;
            end else if (c == 8'h27) begin
                ns.esc  = 1'b0;
                ns.mode = M_CH_OPEN;
            end else if (c == 8'h22) begin
                ns.sline = ns.line;
                ns.mode  = M_STR;
            end else if (c == 8'h0A) begin
                ns.line = line_inc(ns.line);
            end else if (c == "/") begin
                ns.mode = M_C_SLASH;
            end else begin
                vb = 1'b1;
                rb = mk_tok(K_BAD, 32'd0, 1'b0, D_NONE, ns.line);
            end
        end

        // Pack the results to the front of the batch.
        if (va) begin
            batch.slot[0] = ra;
            batch.slot[1] = rb;
            batch.count   = vb ? 2'd2 : 2'd1;
        end else begin
            batch.slot[0] = rb;
            batch.slot[1] = rb;
            batch.count   = {1'b0, vb};
        end
    end

endmodule
`default_nettype wire

### rtl/dftl_outbuf.sv
// Two-word result register that drains the words produced by one source byte.
`default_nettype none
module dftl_outbuf (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  dftl_pkg::lex_batch_t  batch,
    output logic                  can_load,
    output logic                  out_valid,
    input  logic                  out_ready,
    output dftl_pkg::lex_result_t out_word,
    output logic                  out_last
);
    import dftl_pkg::*;

    lex_result_t [1:0] slot_reg;
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    logic              head_reg;
    logic              head_next;
    logic              pop;

    assign out_valid = cnt_reg != 2'd0;
    assign pop       = out_valid && out_ready;
    assign out_word  = slot_reg[head_reg];
    assign out_last  = cnt_reg == 2'd1;
    // A new byte may enter once the last pending word leaves in this cycle.
    assign can_load  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);

    // Count and head pointer.
    always_comb begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        if (load) begin
            cnt_next  = batch.count;
            head_next = 1'b0;
        end else if (pop) begin
            cnt_next  = cnt_reg - 2'd1;
            head_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 2'd0;
            head_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            head_reg <= head_next;
        end
    end

    // Payload slots need no reset.
    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= batch.slot;
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("result count out of range");

    a_head_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> !head_reg) else $error("head not reset after load");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready && !load) |=> $stable(cnt_reg) && $stable(head_reg))
        else $error("pending words changed while stalled");

    a_no_load_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && out_ready)))
        else $error("load would drop a pending word");

endmodule
`default_nettype wire

### rtl/data_file_token_lexer.sv
// Top level of the streaming data-file token lexer.
//
//   channel  dir  tdata                         tuser
//   s_       in   [7:0] source_byte             [0] end_of_input
//   m_       out  [7:0] text_byte, [39:8] value [0] is_text_byte, [4:1] token_kind
//                 [40] overflow, [43:41] diag,  tlast = last word of the byte
//                 [63:44] line_number
//
// Each accepted byte is scanned in the cycle it is taken; its zero, one or two
// words appear on m_ from the next cycle on. A byte yielding at most one word
// sustains one byte per cycle while m_ is ready; a byte yielding two words holds
// s_tready low while the second word drains. Reset returns the scanner to idle on
// line 1. A stall on m_ holds the pending words and blocks s_ while any word waits.
`default_nettype none
module data_file_token_lexer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] source_byte
    input  logic [0:0]  s_tuser,   // [0] end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // text_byte, token_value, overflow_flag, diagnostic, line
    output logic [4:0]  m_tuser,   // is_text_byte, token_kind
    output logic        m_tlast
);
    import dftl_pkg::*;

    lex_state_t  state_reg;
    lex_state_t  state_next;
    lex_batch_t  batch;
    lex_result_t word;
    logic        accept;

    assign accept = s_tvalid && s_tready;

    dftl_step u_step (
        .st    (state_reg),
        .c     (s_tdata),
        .eof   (s_tuser[0]),
        .ns    (state_next),
        .batch (batch)
    );

    dftl_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .batch     (batch),
        .can_load  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (word),
        .out_last  (m_tlast)
    );

    // Scanner state advances once per accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode  <= M_IDLE;
            state_reg.acc   <= 32'd0;
            state_reg.sgn   <= 2'b00;
            state_reg.ovf   <= 1'b0;
            state_reg.digs  <= 1'b0;
            state_reg.line  <= {{(LINE_BITS-1){1'b0}}, 1'b1};
            state_reg.sline <= {{(LINE_BITS-1){1'b0}}, 1'b1};
            state_reg.kw    <= KW_EITHER;
            state_reg.held  <= 8'd0;
            state_reg.esc   <= 1'b0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Output packing.
    assign m_tdata = {word.line, word.diag, word.ovf, word.val, word.tb};
    assign m_tuser = {word.kind, word.txt};

endmodule
`default_nettype wire
